### rtl/core/segmenting_burst_packet_framer_defines.svh
// assertion helpers for the framer
`ifndef SEGMENTING_BURST_PACKET_FRAMER_DEFINES_SVH
`define SEGMENTING_BURST_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer check failed");

// next-cycle implication, checked out of reset
`define SBPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

### rtl/core/sbpf_pkg.sv
package sbpf_pkg;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_PAYLOAD = 1'b1;

  localparam int  CFG_INDEX_W = 1;
  localparam int  CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_LIMIT   = 1'b1;

  localparam logic [15:0] CHUNK_RESET    = 16'hF000;
  localparam logic [8:0]  ID_LIMIT_RESET = 9'h0F1;
  localparam logic [15:0] CHUNK_MAX      = 16'd65529;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd6;
  localparam logic [7:0]  TRAILER_BYTE   = 8'hFF;

  typedef struct packed {
    logic        action;
    logic [7:0]  stream_id;
    logic [31:0] total_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       packet_end;
    logic       last;
  } out_item_t;

  // one classified payload byte, as handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  id;
    logic [15:0] flen;
    logic        header;
    logic        trailer;
    logic        pend;
    logic        sum_payload;
  } seg_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/segmenting_burst_packet_framer.sv
// with an empty queue a payload item's first byte enters the entry queue at the
//   accepting edge and is then registered into the output register
// throughput: one input item per cycle while the entry queue has room; output is
//   one byte per cycle while out_stall is low; the back end frames each segment
//   as length low, length high, id, data bytes, two FF bytes and the checksum
// start items and dropped bytes emit nothing
// reset (rst_n low, synchronous) empties the queue, clears packet state and
//   restores chunk_size 61440 and checksum_id_limit 241
`include "segmenting_burst_packet_framer_defines.svh"

module segmenting_burst_packet_framer #(
  parameter int LENGTH_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sbpf_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sbpf_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [sbpf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sbpf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  sbpf_pkg::q_status_t  q_stat;
  sbpf_pkg::seg_entry_t push_entry;
  sbpf_pkg::seg_entry_t head;
  logic                 push;
  logic                 pop;

  sbpf_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  sbpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sbpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // checksum closes the item that carried the segment's last byte
  `SBPF_ASSERT_NOW(a_cks_is_last, clk, rst_n, out_valid && out_item.frame_end, out_item.last)
  `SBPF_ASSERT_NOW(a_pend_on_cks, clk, rst_n, out_valid && out_item.packet_end, out_item.frame_end)
  // queued work always reaches the output register
  `SBPF_ASSERT_NEXT(a_back_moves, clk, rst_n, !q_stat.empty && !out_valid, out_valid)
  `SBPF_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty)

endmodule

### rtl/core/sbpf_front.sv
module sbpf_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sbpf_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [sbpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sbpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  sbpf_pkg::q_status_t                 q_stat,
  output logic                                push,
  output sbpf_pkg::seg_entry_t                push_entry
);

  logic [15:0]            chunk_r;
  logic [8:0]             limit_r;
  logic                   active_r;
  logic [7:0]             id_r;
  logic [LENGTH_BITS-1:0] left_total_r;
  logic [15:0]            seg_left_r;

  logic                   accept;
  logic [15:0]            chunk_eff;
  logic [15:0]            seg_new;
  logic                   seg_open;
  logic [15:0]            seg_cur;
  logic [15:0]            seg_dec;
  logic [LENGTH_BITS-1:0] total_dec;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (chunk_r == 16'd0) begin
      chunk_eff = 16'd1;
    end else if (chunk_r > sbpf_pkg::CHUNK_MAX) begin
      chunk_eff = sbpf_pkg::CHUNK_MAX;
    end else begin
      chunk_eff = chunk_r;
    end
  end

  assign seg_new   = (left_total_r < LENGTH_BITS'(chunk_eff)) ? left_total_r[15:0] : chunk_eff;
  assign seg_open  = (seg_left_r == 16'd0);
  assign seg_cur   = seg_open ? seg_new : seg_left_r;
  assign seg_dec   = seg_cur - 16'd1;
  assign total_dec = left_total_r - LENGTH_BITS'(1);

  assign push = accept && (in_item.action == sbpf_pkg::ACT_PAYLOAD) && active_r;

  always_comb begin
    push_entry.data        = in_item.data_byte;
    push_entry.id          = id_r;
    push_entry.flen        = seg_new + sbpf_pkg::FRAME_OVERHEAD;
    push_entry.header      = seg_open;
    push_entry.trailer     = (seg_dec == 16'd0);
    push_entry.pend        = (total_dec == '0);
    push_entry.sum_payload = ({1'b0, id_r} < limit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r      <= sbpf_pkg::CHUNK_RESET;
      limit_r      <= sbpf_pkg::ID_LIMIT_RESET;
      active_r     <= 1'b0;
      id_r         <= 8'd0;
      left_total_r <= '0;
      seg_left_r   <= 16'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbpf_pkg::CFG_CHUNK_SIZE: chunk_r <= cfg_wdata;
          sbpf_pkg::CFG_ID_LIMIT:   limit_r <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (accept && (in_item.action == sbpf_pkg::ACT_START)) begin
        // a new start drops whatever segment was open
        id_r         <= in_item.stream_id;
        left_total_r <= in_item.total_length[LENGTH_BITS-1:0];
        seg_left_r   <= 16'd0;
        active_r     <= (in_item.total_length[LENGTH_BITS-1:0] != '0);
      end else if (push) begin
        seg_left_r   <= seg_dec;
        left_total_r <= total_dec;
        if (push_entry.trailer && push_entry.pend) begin
          active_r <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/sbpf_queue.sv
module sbpf_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sbpf_pkg::seg_entry_t  push_entry,
  input  logic                  pop,
  output sbpf_pkg::seg_entry_t  head,
  output sbpf_pkg::q_status_t   q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbpf_pkg::seg_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/sbpf_back.sv
module sbpf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbpf_pkg::q_status_t   q_stat,
  input  sbpf_pkg::seg_entry_t  head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbpf_pkg::out_item_t   out_item
);

  typedef enum logic [2:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_ID,
    PH_DATA,
    PH_FF0,
    PH_FF1,
    PH_CKS
  } phase_t;

  logic                busy_r;
  phase_t              phase_r;
  logic [7:0]          sum_r;
  logic                out_valid_r;
  sbpf_pkg::out_item_t out_r;

  phase_t              cur_phase;
  phase_t              next_phase;
  logic [7:0]          cur_byte;
  logic                add_en;
  logic                cur_last;
  logic                emit;
  logic [7:0]          sum_base;
  logic [7:0]          sum_nxt;

  always_comb begin
    if (busy_r) begin
      cur_phase = phase_r;
    end else if (head.header) begin
      cur_phase = PH_LEN_LO;
    end else begin
      cur_phase = PH_DATA;
    end
  end

  always_comb begin
    cur_byte   = 8'd0;
    add_en     = 1'b1;
    cur_last   = 1'b0;
    next_phase = PH_LEN_LO;
    unique case (cur_phase)
      PH_LEN_LO: begin
        cur_byte   = head.flen[7:0];
        next_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        cur_byte   = head.flen[15:8];
        next_phase = PH_ID;
      end
      PH_ID: begin
        cur_byte   = head.id;
        next_phase = PH_DATA;
      end
      PH_DATA: begin
        cur_byte   = head.data;
        add_en     = head.sum_payload;
        cur_last   = !head.trailer;
        next_phase = PH_FF0;
      end
      PH_FF0: begin
        cur_byte   = sbpf_pkg::TRAILER_BYTE;
        next_phase = PH_FF1;
      end
      PH_FF1: begin
        cur_byte   = sbpf_pkg::TRAILER_BYTE;
        next_phase = PH_CKS;
      end
      PH_CKS: begin
        cur_byte   = 8'd0 - sum_r;
        cur_last   = 1'b1;
      end
      default: begin
        cur_byte = 8'd0;
      end
    endcase
  end

  assign emit     = !q_stat.empty && (!out_valid_r || !out_stall);
  assign pop      = emit && cur_last;
  assign sum_base = (cur_phase == PH_LEN_LO) ? 8'd0 : sum_r;
  assign sum_nxt  = sum_base + (add_en ? cur_byte : 8'd0);

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_LEN_LO;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r         <= 1'b1;
        out_r.out_byte      <= cur_byte;
        out_r.frame_end     <= (cur_phase == PH_CKS);
        out_r.packet_end    <= (cur_phase == PH_CKS) && head.pend;
        out_r.last          <= cur_last;
        sum_r               <= sum_nxt;
        busy_r              <= !cur_last;
        phase_r             <= next_phase;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

### bench/segmenting_burst_packet_framer_checker.sv
module segmenting_burst_packet_framer_checker
  import sbpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     error_count,
  output int                     pending_count,
  output int                     frames_closed,
  output int                     packets_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0] chunk_reg;
  logic [8:0]  limit_reg;

  // packet state
  logic        pkt_open;
  logic [7:0]  pkt_id;
  logic [31:0] bytes_owed;
  logic [15:0] seg_owed;
  logic [7:0]  frame_sum;

  out_item_t framed_bytes[$];
  out_item_t step_bytes[7];
  int        step_count;
  int        errors = 0;
  int        frames = 0;
  int        packets = 0;

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("[%0t] framer mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic fend, input logic pend);
    step_bytes[step_count] = '{out_byte: b, frame_end: fend, packet_end: pend, last: 1'b0};
    step_count++;
    frame_sum = frame_sum + b;
  endtask

  task automatic predict_frame_bytes(input in_item_t it);
    logic [15:0] chunk;
    logic [15:0] seg;
    logic [15:0] flen;
    logic [7:0]  sum_before;
    logic        closes_packet;
    step_count = 0;
    if (it.action == ACT_START) begin
      pkt_id = it.stream_id;
      bytes_owed = it.total_length;
      seg_owed = 16'd0;
      frame_sum = 8'd0;
      pkt_open = (it.total_length != 32'd0);
    end else if (pkt_open) begin
      if (seg_owed == 16'd0) begin
        // open a new frame: length low, length high, id
        if (chunk_reg == 16'd0) chunk = 16'd1;
        else if (chunk_reg > CHUNK_MAX) chunk = CHUNK_MAX;
        else chunk = chunk_reg;
        seg = (bytes_owed < {16'd0, chunk}) ? bytes_owed[15:0] : chunk;
        flen = seg + FRAME_OVERHEAD;
        seg_owed = seg;
        frame_sum = 8'd0;
        put_byte(flen[7:0], 1'b0, 1'b0);
        put_byte(flen[15:8], 1'b0, 1'b0);
        put_byte(pkt_id, 1'b0, 1'b0);
      end
      sum_before = frame_sum;
      put_byte(it.data_byte, 1'b0, 1'b0);
      // payload only counts toward the checksum for ids below the limit
      if ({1'b0, pkt_id} >= limit_reg) frame_sum = sum_before;
      seg_owed = seg_owed - 16'd1;
      bytes_owed = bytes_owed - 32'd1;
      if (seg_owed == 16'd0) begin
        closes_packet = (bytes_owed == 32'd0);
        put_byte(TRAILER_BYTE, 1'b0, 1'b0);
        put_byte(TRAILER_BYTE, 1'b0, 1'b0);
        put_byte(8'd0 - frame_sum, 1'b1, closes_packet);
        frame_sum = 8'd0;
        if (closes_packet) pkt_open = 1'b0;
      end
    end
    for (int k = 0; k < step_count; k++) begin
      if (k == step_count - 1) step_bytes[k].last = 1'b1;
      framed_bytes.push_back(step_bytes[k]);
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (framed_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h arrived with nothing pending", got.out_byte));
    end else begin
      want = framed_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end %b, wanted %b", got.frame_end, want.frame_end));
      if (got.packet_end !== want.packet_end)
        report_mismatch($sformatf("packet_end %b, wanted %b", got.packet_end,
                                  want.packet_end));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, wanted %b", got.last, want.last));
      if (want.frame_end) frames++;
      if (want.packet_end) packets++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chunk_reg = CHUNK_RESET;
      limit_reg = ID_LIMIT_RESET;
      pkt_open = 1'b0;
      pkt_id = 8'd0;
      bytes_owed = 32'd0;
      seg_owed = 16'd0;
      frame_sum = 8'd0;
      framed_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHUNK_SIZE: chunk_reg = cfg_wdata;
          CFG_ID_LIMIT:   limit_reg = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_frame_bytes(in_item);
      if (out_valid && !out_stall) check_byte(out_item);
    end
    error_count <= errors;
    pending_count <= framed_bytes.size();
    frames_closed <= frames;
    packets_closed <= packets;
  end

endmodule

### bench/segmenting_burst_packet_framer_test.sv
module segmenting_burst_packet_framer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int         error_count;
  int         pending_count;
  int         frames_closed;
  int         packets_closed;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  logic [8:0] id_limit = ID_LIMIT_RESET;

  segmenting_burst_packet_framer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  segmenting_burst_packet_framer_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .pending_count  (pending_count),
    .frames_closed  (frames_closed),
    .packets_closed (packets_closed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
               pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // unused fields are randomized so their bits move too
  function automatic in_item_t start_item(input logic [7:0] id, input logic [31:0] len);
    in_item_t it;
    it.action = ACT_START;
    it.stream_id = id;
    it.total_length = len;
    it.data_byte = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t payload_item(input logic [7:0] data);
    in_item_t it;
    it.action = ACT_PAYLOAD;
    it.stream_id = 8'($urandom_range(255));
    it.total_length = $urandom();
    it.data_byte = data;
    return it;
  endfunction

  // ids cluster around the checksum limit, with 00, FF and random ids mixed in
  function automatic logic [7:0] pick_id();
    case ($urandom_range(5))
      0: return id_limit[7:0] - 8'd1;
      1: return id_limit[7:0];
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] chunk, input logic [8:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHUNK_SIZE;
    cfg_wdata <= chunk;
    @(posedge clk);
    cfg_index <= CFG_ID_LIMIT;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    id_limit = limit;
  endtask

  task automatic run_packets(input int budget);
    int          used;
    int          len;
    int          sent_bytes;
    int          shape;
    logic [31:0] claimed;
    used = 0;
    while (used < budget) begin
      shape = $urandom_range(99);
      if (shape < 12) begin
        // empty packet, then stray bytes that the idle block drops
        send_item(start_item(pick_id(), 32'd0));
        repeat ($urandom_range(2, 1)) send_item(payload_item(8'($urandom_range(255))));
        used += 1;
      end else if (shape < 27) begin
        // packet cut short, the next start abandons it
        if ($urandom_range(1)) claimed = $urandom() | 32'd8;
        else claimed = $urandom_range(14, 2);
        send_item(start_item(pick_id(), claimed));
        sent_bytes = $urandom_range((claimed < 32'd7) ? claimed - 1 : 6, 0);
        repeat (sent_bytes) send_item(payload_item(8'($urandom_range(255))));
        used += 1 + sent_bytes;
      end else begin
        if ($urandom_range(9) == 0) len = $urandom_range(30, 15);
        else len = $urandom_range(12, 1);
        send_item(start_item(pick_id(), 32'(len)));
        repeat (len) send_item(payload_item(8'($urandom_range(255))));
        used += 1 + len;
      end
    end
    // leave the block idle for the next register write
    send_item(start_item(pick_id(), 32'd0));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under the reset register values
    send_item(payload_item(8'hAA));                 // idle, dropped
    send_item(start_item(8'h00, 32'd0));            // empty packet emits nothing
    send_item(payload_item(8'h55));                 // still idle
    send_item(start_item(8'hFF, 32'd1));            // single byte frame, payload not summed
    send_item(payload_item(8'hFF));
    send_item(start_item(8'h00, 32'd3));
    send_item(payload_item(8'h00));
    send_item(payload_item(8'hFF));
    send_item(payload_item(8'h80));
    send_item(start_item(8'hF0, 32'd5));            // highest id that is summed
    send_item(payload_item(8'h01));
    send_item(payload_item(8'h02));
    send_item(start_item(8'hF1, 32'd2));            // abandons open packet mid-frame
    send_item(payload_item(8'h7F));
    send_item(payload_item(8'h80));
    send_item(start_item(8'h5A, 32'hFFFF_FFFF));    // full-size frame header
    send_item(payload_item(8'hC3));
    send_item(start_item(8'hA5, 32'h0001_0000));
    send_item(payload_item(8'h3C));
    send_item(start_item(8'h00, 32'd0));
    wait_drained();

    set_config(16'd3, 9'd256);
    run_packets(28);
    wait_drained();

    idle_pct = 65;
    set_config(16'd1, 9'd0);
    run_packets(28);
    wait_drained();

    idle_pct = 0;
    stall_pct = 65;
    set_config(16'd0, 9'h1FF);
    run_packets(28);
    wait_drained();

    idle_pct = 32;
    stall_pct = 32;
    set_config(16'hFFFF, 9'd128);
    run_packets(28);
    wait_drained();

    idle_pct = 0;
    stall_pct = 0;
    set_config(16'd4, 9'd241);
    run_packets(14);
    // hold the sender until every byte is out, then resume
    wait_drained();
    idle_pct = 32;
    stall_pct = 65;
    run_packets(14);
    wait_drained();

    idle_pct = 65;
    stall_pct = 32;
    set_config(16'd65529, 9'd1);
    run_packets(14);
    wait_drained();

    $display("covered %0d input items across seven register settings", items_sent);
    $display("checked %0d closed frames, %0d of them ending a packet", frames_closed,
             packets_closed);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sbpf_pkg.sv
rtl/core/sbpf_front.sv
rtl/core/sbpf_queue.sv
rtl/core/sbpf_back.sv
rtl/core/segmenting_burst_packet_framer.sv
bench/segmenting_burst_packet_framer_checker.sv
bench/segmenting_burst_packet_framer_test.sv
